// File: sv/stip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types and constants of the serial, timer and interrupt port unit.
// ----------------------------------------------------------------------------
package stip_pkg;

  // Kind of an input word
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RX    = 2'd3
  } stip_cmd_e;

  // Port offsets
  localparam logic [3:0] REG_STATUS = 4'd0;  // status read / baud write
  localparam logic [3:0] REG_DATA   = 4'd1;  // receive read / transmit write
  localparam logic [3:0] REG_CMD    = 4'd2;  // command write
  localparam logic [3:0] REG_INT    = 4'd3;  // interrupt address read / mask write
  localparam int         REG_TIMER0 = 5;     // first timer load port

  // Configuration register indexes
  localparam logic CFG_CARRIER_TIED = 1'b0;
  localparam logic CFG_CTS_TIED     = 1'b1;

  // Read values and status bits
  localparam logic [7:0] RD_NONE        = 8'hFF;
  localparam logic [7:0] INT_OP_BASE    = 8'hC7;
  localparam logic [7:0] STAT_MARK      = 8'h04;
  localparam logic [7:0] STAT_INT       = 8'h20;
  localparam logic [7:0] STAT_RX_FULL   = 8'h40;
  localparam logic [7:0] STAT_TX_READY  = 8'h80;
  localparam int         CMD_BIT_RES    = 0;
  localparam int         CMD_BIT_BRK    = 1;
  localparam int         CMD_BIT_HBD    = 4;
  localparam int         BAUD_BIT_STOP1 = 7;

  localparam int TIMER_MAX = 8;

  // Priority bit of each timer
  localparam logic [2:0] TIMER_BIT_MAP [TIMER_MAX] =
    '{3'd0, 3'd1, 3'd3, 3'd6, 3'd7, 3'd2, 3'd4, 3'd5};

  localparam int BAUD_W = 17;

  typedef struct packed {
    logic       tx_room;
    logic       cts_line;
    logic       carrier_line;
    logic [7:0] rx_byte;
    logic [7:0] write_data;
    logic [3:0] reg_select;
    stip_cmd_e  command;
  } stip_in_t;

  typedef struct packed {
    logic              break_out;
    logic              two_stop_bits;
    logic [BAUD_W-1:0] line_baud;
    logic              int_pending;
    logic [7:0]        tx_byte;
    logic              tx_strobe;
    logic              rx_taken;
    logic [7:0]        read_data;
  } stip_out_t;

  // Rate code to baud; zero means the line is disabled
  function automatic logic [BAUD_W-1:0] rate_baud(input logic [2:0] rate);
    logic [BAUD_W-1:0] b;
    case (rate)
      3'd1:    b = BAUD_W'(110);
      3'd2:    b = BAUD_W'(150);
      3'd3:    b = BAUD_W'(300);
      3'd4:    b = BAUD_W'(1200);
      3'd5:    b = BAUD_W'(2400);
      3'd6:    b = BAUD_W'(4800);
      3'd7:    b = BAUD_W'(9600);
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: sv/stip_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stip_in_stage
// Input register: holds one accepted word until the core takes it.
// ----------------------------------------------------------------------------
module stip_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire stip_pkg::stip_in_t in_word_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      stip_pkg::stip_in_t out_word_o
);
  import stip_pkg::*;

  logic     valid_q, valid_d;
  stip_in_t word_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/stip_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stip_core
// Register file, timers and interrupt encoder with the result register.
// ----------------------------------------------------------------------------
module stip_core #(
  parameter int TIMER_COUNT = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire stip_pkg::stip_in_t in_word_i,
  output      logic               res_valid_o,
  input  wire logic               res_ready_i,
  output      stip_pkg::stip_out_t res_word_o
);
  import stip_pkg::*;

  typedef logic [TIMER_COUNT-1:0][7:0] cnt_t;

  logic       carrier_tied_q, cts_tied_q;
  logic [7:0] rx_hold_q, rx_hold_d;
  logic       rx_full_q, rx_full_d;
  logic [7:0] cmd_q, cmd_d;
  logic [2:0] rate_q, rate_d;
  logic       stop1_q, stop1_d;
  logic [7:0] mask_q, mask_d;
  cnt_t       cnt_q, cnt_d;
  logic [TIMER_COUNT-1:0] armed_q, armed_d;

  logic       res_valid_q, res_valid_d;
  stip_out_t  res_q, res_d;
  logic       adv;
  logic [7:0] active_q;
  logic [2:0] win_bit;
  logic [BAUD_W-1:0] baud;

  function automatic logic [7:0] pend_f(input cnt_t cnt, input logic [TIMER_COUNT-1:0] arm);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      if (arm[i] && cnt[i] == 8'd0) begin
        p[TIMER_BIT_MAP[i]] = 1'b1;
      end
    end
    return p;
  endfunction

  assign in_ready_o  = !res_valid_q || res_ready_i;
  assign adv         = in_valid_i && in_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_word_o  = res_q;
  assign active_q    = pend_f(cnt_q, armed_q) & mask_q;

  // Lowest active bit wins
  always_comb begin
    win_bit = '0;
    for (int b = 7; b >= 0; b--) begin
      if (active_q[b]) begin
        win_bit = 3'(b);
      end
    end
  end

  always_comb begin
    rx_hold_d = rx_hold_q;
    rx_full_d = rx_full_q;
    cmd_d     = cmd_q;
    rate_d    = rate_q;
    stop1_d   = stop1_q;
    mask_d    = mask_q;
    cnt_d     = cnt_q;
    armed_d   = armed_q;
    res_d     = '0;

    case (in_word_i.command)
      CMD_TICK: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (armed_q[i] && cnt_q[i] != 8'd0) begin
            cnt_d[i] = cnt_q[i] - 8'd1;
          end
        end
      end
      CMD_WRITE: begin
        case (in_word_i.reg_select)
          REG_STATUS: begin
            // highest set bit picks the rate
            rate_d = '0;
            for (int b = 0; b < 7; b++) begin
              if (in_word_i.write_data[b]) begin
                rate_d = 3'(b + 1);
              end
            end
            stop1_d = in_word_i.write_data[BAUD_BIT_STOP1];
          end
          REG_DATA: begin
            res_d.tx_strobe = 1'b1;
            res_d.tx_byte   = in_word_i.write_data;
          end
          REG_CMD: begin
            cmd_d = in_word_i.write_data;
            if (in_word_i.write_data[CMD_BIT_RES]) begin
              rx_full_d = 1'b0;
              rx_hold_d = '0;
              armed_d   = '0;
            end
          end
          REG_INT: begin
            mask_d = in_word_i.write_data;
          end
          default: begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
              if (in_word_i.reg_select == 4'(REG_TIMER0 + i)) begin
                cnt_d[i]   = in_word_i.write_data;
                armed_d[i] = 1'b1;
              end
            end
          end
        endcase
      end
      CMD_READ: begin
        case (in_word_i.reg_select)
          REG_STATUS: begin
            // line levels are sampled by this read
            res_d.read_data = STAT_MARK;
            if (rx_full_q) begin
              res_d.read_data = res_d.read_data | STAT_RX_FULL;
            end
            if ((cts_tied_q || in_word_i.cts_line) && in_word_i.tx_room) begin
              res_d.read_data = res_d.read_data | STAT_TX_READY;
            end
            if (active_q != 8'd0) begin
              res_d.read_data = res_d.read_data | STAT_INT;
            end
          end
          REG_DATA: begin
            rx_full_d       = 1'b0;
            res_d.read_data = rx_hold_q;
          end
          REG_INT: begin
            if (active_q == 8'd0) begin
              res_d.read_data = RD_NONE;
            end else begin
              res_d.read_data = INT_OP_BASE + 8'({win_bit, 3'b000});
              for (int i = 0; i < TIMER_COUNT; i++) begin
                if (TIMER_BIT_MAP[i] == win_bit) begin
                  armed_d[i] = 1'b0;
                end
              end
            end
          end
          default: begin
            res_d.read_data = RD_NONE;
          end
        endcase
      end
      CMD_RX: begin
        if ((carrier_tied_q || in_word_i.carrier_line) && !rx_full_q) begin
          rx_hold_d      = in_word_i.rx_byte;
          rx_full_d      = 1'b1;
          res_d.rx_taken = 1'b1;
        end
      end
      default: begin
      end
    endcase

    baud = rate_baud(rate_d);
    if (cmd_d[CMD_BIT_HBD]) begin
      baud = baud << 3;
    end
    res_d.int_pending   = |(pend_f(cnt_d, armed_d) & mask_d);
    res_d.line_baud     = baud;
    res_d.two_stop_bits = !stop1_d;
    res_d.break_out     = cmd_d[CMD_BIT_BRK];
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (adv) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_tied_q <= 1'b1;
      cts_tied_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CARRIER_TIED: carrier_tied_q <= cfg_wdata_i;
        CFG_CTS_TIED:     cts_tied_q     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold_q   <= '0;
      rx_full_q   <= 1'b0;
      cmd_q       <= '0;
      rate_q      <= '0;
      stop1_q     <= 1'b0;
      mask_q      <= '0;
      cnt_q       <= '0;
      armed_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (adv) begin
        rx_hold_q <= rx_hold_d;
        rx_full_q <= rx_full_d;
        cmd_q     <= cmd_d;
        rate_q    <= rate_d;
        stop1_q   <= stop1_d;
        mask_q    <= mask_d;
        cnt_q     <= cnt_d;
        armed_q   <= armed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  // State and result register move together, so the held word matches the state
  a_pending_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.int_pending == (active_q != 8'd0))
    else $error("int_pending disagrees with timer state");

  a_taken_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.rx_taken |-> rx_full_q)
    else $error("latched byte without full flag");

  a_reset_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_word_i.command == CMD_WRITE && in_word_i.reg_select == REG_CMD &&
    in_word_i.write_data[CMD_BIT_RES] |=> !rx_full_q && armed_q == '0)
    else $error("receiver or timers survived a reset command");

  a_strobe_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.tx_strobe |-> res_q.read_data == 8'd0 && !res_q.rx_taken)
    else $error("transmit word carries read data");

endmodule
`default_nettype wire

// File: sv/serial_timer_interrupt_port_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_timer_interrupt_port_unit
// Serial port, one-shot interval timers and interrupt encoder behind a stream.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     tuser: command; tdata: port access
// m_axis    out  m_axis_tvalid/tready     tdata: read data, line and irq state
// cfg       in   cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// One word per cycle while m_axis is ready; each word sees the state left by the previous.
// Each word goes through the input register, then through the register file
// and timer logic into the result register.
// Reset clears all state, disarms the timers and ties carrier and CTS on.
// A stalled m_axis holds its word; s_axis takes at most one more, into the
// input register if it is empty, and then stops.
// ----------------------------------------------------------------------------
module serial_timer_interrupt_port_unit #(
  parameter int TIMER_COUNT = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser,
  // [3:0] reg_select, [11:4] write_data, [19:12] rx_byte, [20] carrier_line,
  // [21] cts_line, [22] tx_room, [23] zero
  input  wire logic [23:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [8] rx_taken, [9] tx_strobe, [17:10] tx_byte,
  // [18] int_pending, [35:19] line_baud, [36] two_stop_bits, [37] break_out,
  // [39:38] zero
  output      logic [39:0] m_axis_tdata
);
  import stip_pkg::*;

  stip_in_t  in_word, core_word;
  stip_out_t res_word;
  logic      core_valid, core_ready;

  always_comb begin
    in_word              = '0;
    in_word.command      = stip_cmd_e'(s_axis_tuser);
    in_word.reg_select   = s_axis_tdata[3:0];
    in_word.write_data   = s_axis_tdata[11:4];
    in_word.rx_byte      = s_axis_tdata[19:12];
    in_word.carrier_line = s_axis_tdata[20];
    in_word.cts_line     = s_axis_tdata[21];
    in_word.tx_room      = s_axis_tdata[22];
  end

  stip_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_word_i   (in_word),
    .out_valid_o (core_valid),
    .out_ready_i (core_ready),
    .out_word_o  (core_word)
  );

  stip_core #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (core_valid),
    .in_ready_o  (core_ready),
    .in_word_i   (core_word),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_word_o  (res_word)
  );

  assign m_axis_tdata = {2'b00, res_word};

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial, timer and interrupt port unit. Words of
// ticks, bus writes, bus reads and line bytes go in on the input stream. An
// in-bench model of the port registers, timers and interrupt encoder predicts
// every result word, which is compared field by field on the output stream.
// Both streams idle at random, and the carrier and CTS tie-offs change
// between phases.
// ----------------------------------------------------------------------------
module tb;
  import stip_pkg::*;

  localparam int TIMERS = 5;
  localparam int PHASES = 5;
  localparam int WORDS_PER_PHASE = 300;
  localparam int BAUD_RATES [7] = '{110, 150, 300, 1200, 2400, 4800, 9600};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  serial_timer_interrupt_port_unit #(
    .TIMER_COUNT(TIMERS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Port state as the block should hold it
  logic       carrier_tied = 1'b1;
  logic       cts_tied     = 1'b1;
  logic [7:0] rx_hold      = '0;
  logic       rx_valid     = 1'b0;
  logic [7:0] cmd_reg      = '0;
  logic [2:0] rate_code    = '0;
  logic       stop1        = 1'b0;
  logic [7:0] mask_reg     = '0;
  logic [7:0] tmr_count [TIMERS];
  logic       tmr_armed [TIMERS];
  logic       cts_smp      = 1'b1;
  logic       room_smp     = 1'b1;

  stip_in_t  word_q [$];
  stip_out_t response_q [$];
  stip_in_t  cur_word;

  int in_launched  = 0;
  int in_accepted  = 0;
  int out_accepted = 0;
  int out_seen     = 0;
  int src_gap      = 0;
  int snk_stall    = 0;
  bit src_idle     = 1'b1;
  bit snk_idle     = 1'b1;
  int bad_count    = 0;
  int kind_count [4] = '{0, 0, 0, 0};
  int irq_acks     = 0;
  int bytes_latched = 0;

  initial begin
    for (int i = 0; i < TIMERS; i++) begin
      tmr_count[i] = '0;
      tmr_armed[i] = 1'b0;
    end
  end

  function automatic logic [7:0] pending_bits();
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < TIMERS; i++)
      if (tmr_armed[i] && tmr_count[i] == 8'd0) p[TIMER_BIT_MAP[i]] = 1'b1;
    return p;
  endfunction

  function automatic void sample_lines(input stip_in_t w);
    cts_smp  = cts_tied ? 1'b1 : w.cts_line;
    room_smp = w.tx_room;
  endfunction

  // Append one word to the pending stimulus
  function automatic void enqueue_word(input stip_in_t w);
    word_q = {word_q, w};
  endfunction

  // Apply one word to the port state and return the result word it causes
  function automatic stip_out_t port_response(input stip_in_t w);
    stip_out_t  r;
    logic [7:0] active;
    int         bit_no;
    logic [BAUD_W-1:0] baud;
    r = '0;
    kind_count[w.command]++;
    case (w.command)
      CMD_TICK: begin
        for (int i = 0; i < TIMERS; i++)
          if (tmr_armed[i] && tmr_count[i] != 8'd0) tmr_count[i] = tmr_count[i] - 8'd1;
      end
      CMD_WRITE: begin
        case (w.reg_select)
          REG_STATUS: begin
            rate_code = '0;
            // ascending scan leaves the highest set bit
            for (int b = 0; b < 7; b++)
              if (w.write_data[b]) rate_code = 3'(b + 1);
            stop1 = w.write_data[BAUD_BIT_STOP1];
          end
          REG_DATA: begin
            r.tx_strobe = 1'b1;
            r.tx_byte   = w.write_data;
          end
          REG_CMD: begin
            cmd_reg = w.write_data;
            if (w.write_data[CMD_BIT_RES]) begin
              rx_valid = 1'b0;
              rx_hold  = '0;
              for (int i = 0; i < TIMERS; i++) tmr_armed[i] = 1'b0;
              sample_lines(w);
            end
          end
          REG_INT: mask_reg = w.write_data;
          default: begin
            if (w.reg_select >= REG_TIMER0 && w.reg_select < REG_TIMER0 + TIMERS) begin
              tmr_count[w.reg_select - REG_TIMER0] = w.write_data;
              tmr_armed[w.reg_select - REG_TIMER0] = 1'b1;
            end
          end
        endcase
      end
      CMD_READ: begin
        case (w.reg_select)
          REG_STATUS: begin
            sample_lines(w);
            r.read_data = STAT_MARK;
            if (rx_valid) r.read_data |= STAT_RX_FULL;
            if (cts_smp && room_smp) r.read_data |= STAT_TX_READY;
            if ((pending_bits() & mask_reg) != 8'd0) r.read_data |= STAT_INT;
          end
          REG_DATA: begin
            sample_lines(w);
            rx_valid    = 1'b0;
            r.read_data = rx_hold;
          end
          REG_INT: begin
            active = pending_bits() & mask_reg;
            if (active == 8'd0) begin
              r.read_data = RD_NONE;
            end else begin
              bit_no = 0;
              // descending scan leaves the lowest set bit
              for (int b = 7; b >= 0; b--)
                if (active[b]) bit_no = b;
              for (int i = 0; i < TIMERS; i++)
                if (TIMER_BIT_MAP[i] == bit_no) tmr_armed[i] = 1'b0;
              r.read_data = INT_OP_BASE + 8'(8 * bit_no);
              irq_acks++;
            end
          end
          default: r.read_data = RD_NONE;
        endcase
      end
      CMD_RX: begin
        if ((carrier_tied || w.carrier_line) && !rx_valid) begin
          rx_hold    = w.rx_byte;
          rx_valid   = 1'b1;
          r.rx_taken = 1'b1;
          bytes_latched++;
        end
      end
      default: ;
    endcase
    baud = (rate_code != 3'd0) ? BAUD_W'(BAUD_RATES[rate_code - 1]) : '0;
    if (cmd_reg[CMD_BIT_HBD]) baud = baud * BAUD_W'(8);
    r.int_pending   = (pending_bits() & mask_reg) != 8'd0;
    r.line_baud     = baud;
    r.two_stop_bits = !stop1;
    r.break_out     = cmd_reg[CMD_BIT_BRK];
    return r;
  endfunction

  function automatic stip_in_t port_word(input stip_cmd_e c, input logic [3:0] sel,
                                         input logic [7:0] d);
    stip_in_t w;
    w.command      = c;
    w.reg_select   = sel;
    w.write_data   = d;
    w.rx_byte      = d;
    w.carrier_line = 1'($urandom);
    w.cts_line     = 1'($urandom);
    w.tx_room      = 1'($urandom);
    return w;
  endfunction

  // Mostly timer loads, ticks and acknowledges so that interrupts fire often
  function automatic stip_in_t draw_word();
    stip_in_t w;
    int       r;
    logic [7:0] d;
    r = $urandom_range(0, 99);
    d = 8'($urandom);
    if (r < 30) begin
      w = port_word(CMD_TICK, 4'($urandom), d);
    end else if (r < 42) begin
      if ($urandom_range(0, 3) != 0) d = 8'($urandom_range(0, 6));
      w = port_word(CMD_WRITE, 4'(REG_TIMER0 + $urandom_range(0, TIMERS - 1)), d);
    end else if (r < 52) begin
      w = port_word(CMD_READ, REG_INT, d);
    end else if (r < 60) begin
      w = port_word(CMD_READ, REG_STATUS, d);
    end else if (r < 68) begin
      w = port_word(CMD_READ, REG_DATA, d);
    end else if (r < 80) begin
      w = port_word(CMD_RX, 4'($urandom), d);
    end else if (r < 84) begin
      w = port_word(CMD_WRITE, REG_INT, $urandom_range(0, 1) ? 8'hFF : d);
    end else if (r < 88) begin
      w = port_word(CMD_WRITE, REG_STATUS, d);
    end else if (r < 92) begin
      // keep RES rare so that armed timers survive
      if ($urandom_range(0, 7) != 0) d[CMD_BIT_RES] = 1'b0;
      w = port_word(CMD_WRITE, REG_CMD, d);
    end else if (r < 95) begin
      w = port_word(CMD_WRITE, REG_DATA, d);
    end else begin
      w = port_word(stip_cmd_e'($urandom_range(0, 3)), 4'($urandom), d);
    end
    return w;
  endfunction

  task automatic load_directed();
    enqueue_word(port_word(CMD_READ, REG_STATUS, 8'h00));
    enqueue_word(port_word(CMD_READ, REG_INT, 8'h00));      // nothing pending
    enqueue_word(port_word(CMD_WRITE, REG_STATUS, 8'h00));  // line disabled
    enqueue_word(port_word(CMD_WRITE, REG_STATUS, 8'h7F));  // highest rate
    enqueue_word(port_word(CMD_WRITE, REG_STATUS, 8'h81));  // lowest rate, one stop
    enqueue_word(port_word(CMD_WRITE, REG_STATUS, 8'hC0));
    enqueue_word(port_word(CMD_WRITE, REG_CMD, 8'h12));     // HBD and BRK
    enqueue_word(port_word(CMD_WRITE, REG_DATA, 8'hFF));
    enqueue_word(port_word(CMD_RX, REG_DATA, 8'hA5));
    enqueue_word(port_word(CMD_RX, REG_DATA, 8'h5A));       // refused, holding full
    enqueue_word(port_word(CMD_READ, REG_STATUS, 8'h00));
    enqueue_word(port_word(CMD_READ, REG_DATA, 8'h00));
    enqueue_word(port_word(CMD_WRITE, REG_INT, 8'hFF));
    enqueue_word(port_word(CMD_WRITE, 4'(REG_TIMER0), 8'h00));      // pending at once
    enqueue_word(port_word(CMD_WRITE, 4'(REG_TIMER0 + 4), 8'h02));  // top interrupt bit
    repeat (3) enqueue_word(port_word(CMD_TICK, REG_STATUS, 8'h00));
    enqueue_word(port_word(CMD_READ, REG_STATUS, 8'h00));
    repeat (3) enqueue_word(port_word(CMD_READ, REG_INT, 8'h00));
    enqueue_word(port_word(CMD_WRITE, 4'(REG_TIMER0 + 1), 8'h00));
    enqueue_word(port_word(CMD_WRITE, REG_CMD, 8'hFF));     // RES disarms everything
    enqueue_word(port_word(CMD_READ, REG_INT, 8'h00));
    enqueue_word(port_word(CMD_READ, REG_CMD, 8'h00));
    enqueue_word(port_word(CMD_READ, 4'hF, 8'h00));
    enqueue_word(port_word(CMD_READ, 4'(REG_TIMER0), 8'h00));
    enqueue_word(port_word(CMD_WRITE, 4'd4, 8'h55));
    enqueue_word(port_word(CMD_WRITE, 4'hF, 8'hAA));
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_CARRIER_TIED) carrier_tied = val;
    else cts_tied = val;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      bad_count++;
      if (bad_count <= 10)
        $display("result %0d %s: expected %0h, got %0h", out_accepted, name, want, got);
    end
  endtask

  // Input driver: hold a word until taken, then wait out its gap
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_accepted == in_launched) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          s_axis_tuser  <= cur_word.command;
          s_axis_tdata  <= {1'b0, cur_word.tx_room, cur_word.cts_line,
                            cur_word.carrier_line, cur_word.rx_byte,
                            cur_word.write_data, cur_word.reg_select};
          s_axis_tvalid <= 1'b1;
          in_launched++;
          if ($urandom_range(0, 63) == 0) src_idle = !src_idle;
          src_gap = src_idle ? $urandom_range(0, 3) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side ready: draw a new stall after every word taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_accepted != out_seen) begin
        out_seen = out_accepted;
        if ($urandom_range(0, 63) == 0) snk_idle = !snk_idle;
        snk_stall = snk_idle ? $urandom_range(0, 3) : 0;
      end
      if (snk_stall > 0) begin
        snk_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    stip_out_t want;
    stip_out_t got;
    stip_out_t pred;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_accepted++;
        if (response_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("result %0d arrived with none expected", out_accepted);
        end else begin
          want = response_q.pop_front();
          got  = stip_out_t'(m_axis_tdata[37:0]);
          check_field("read_data", want.read_data, got.read_data);
          check_field("rx_taken", want.rx_taken, got.rx_taken);
          check_field("tx_strobe", want.tx_strobe, got.tx_strobe);
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("int_pending", want.int_pending, got.int_pending);
          check_field("line_baud", want.line_baud, got.line_baud);
          check_field("two_stop_bits", want.two_stop_bits, got.two_stop_bits);
          check_field("break_out", want.break_out, got.break_out);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = port_response(cur_word);
        response_q = {response_q, pred};
        in_accepted++;
      end
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = 1'b0;
    cfg_wdata_i   = 1'b0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_cfg(CFG_CARRIER_TIED, (ph == 0 || ph == 3));
      write_cfg(CFG_CTS_TIED, (ph == 0 || ph == 2));
      if (ph == 0) load_directed();
      repeat (WORDS_PER_PHASE) enqueue_word(draw_word());
      while (word_q.size() != 0 || in_accepted != in_launched || response_q.size() != 0)
        @(posedge clk_i);
    end
    // catch any stray word after the last expected one
    repeat (6) @(posedge clk_i);
    if (response_q.size() != 0) bad_count += response_q.size();
    $display("%0d words over %0d tie-off settings: %0d ticks, %0d writes, %0d reads",
             in_accepted, PHASES, kind_count[0], kind_count[1], kind_count[2]);
    $display("%0d offers, %0d interrupts acknowledged, %0d line bytes latched, %0d errors",
             kind_count[3], irq_acks, bytes_latched, bad_count);
    if (bad_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
